/* src/hvt_pkg.sv */
// Package for the homogeneous vertex transform and bounding-box unit.
// Holds opcodes, configuration constants and controller/datapath structs.
// No dependencies.
`default_nettype none

package hvt_pkg;

    localparam int DEF_FRAC_BITS  = 16;
    localparam int DEF_COORD_BITS = 32;
    localparam int NUM_PAIRS      = 8;
    localparam int CFG_IDX_BITS   = 4;
    localparam int PAIR_IDX_BITS  = 3;

    // Item kinds carried in tuser
    localparam logic [1:0] OP_VERTEX = 2'd0;
    localparam logic [1:0] OP_NORMAL = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;
    localparam logic [1:0] OP_NOP    = 2'd3;

    // Matrix register reset values: identity in Q16.16
    function automatic logic [63:0] pair_reset(input logic [PAIR_IDX_BITS-1:0] idx);
        logic [63:0] val;
        unique case (idx)
            3'd0:    val = 64'h0000_0000_0001_0000;
            3'd2:    val = 64'h0001_0000_0000_0000;
            3'd5:    val = 64'h0000_0000_0001_0000;
            3'd7:    val = 64'h0001_0000_0000_0000;
            default: val = 64'h0;
        endcase
        return val;
    endfunction

    // Commands from controller to datapath
    typedef struct packed {
        logic       load_in;
        logic       mul;
        logic       acc;
        logic       row_end;
        logic [1:0] row;
        logic [1:0] col;
        logic       div_load;
        logic       div_step;
        logic       div_end;
        logic [1:0] idx;
        logic       finish;
    } hvt_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic [1:0] op;
        logic       w_zero;
        logic       out_free;
    } hvt_stat_t;

endpackage

`default_nettype wire

/* src/hvt_ctrl.sv */
// Sequencer for the transform unit: walks the multiply-accumulate schedule
// and the serial divisions. Depends on hvt_pkg.
`default_nettype none

module hvt_ctrl #(
    parameter int DIV_BITS = hvt_pkg::DEF_COORD_BITS + hvt_pkg::DEF_FRAC_BITS + 1
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire logic [1:0]       in_op,
    output logic                  in_ready,
    input  wire hvt_pkg::hvt_stat_t stat,
    output hvt_pkg::hvt_cmd_t     cmd
);
    import hvt_pkg::*;

    localparam int CNT_BITS = $clog2(DIV_BITS);
    localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(DIV_BITS - 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MUL   = 3'd1;
    localparam logic [2:0] ST_ACC   = 3'd2;
    localparam logic [2:0] ST_ROW   = 3'd3;
    localparam logic [2:0] ST_DLOAD = 3'd4;
    localparam logic [2:0] ST_DSTEP = 3'd5;
    localparam logic [2:0] ST_DEND  = 3'd6;
    localparam logic [2:0] ST_FIN   = 3'd7;

    logic [2:0]          state_reg, state_next;
    logic [1:0]          row_reg, row_next;
    logic [1:0]          col_reg, col_next;
    logic [1:0]          idx_reg, idx_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [1:0]          last_row;

    assign last_row = (stat.op == OP_VERTEX) ? 2'd3 : 2'd2;
    assign in_ready = (state_reg == ST_IDLE);

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        idx_next   = idx_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.row    = row_reg;
        cmd.col    = col_reg;
        cmd.idx    = idx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    row_next    = 2'd0;
                    col_next    = 2'd0;
                    idx_next    = 2'd0;
                    if (in_op == OP_VERTEX || in_op == OP_NORMAL)
                        state_next = ST_MUL;
                    else
                        state_next = ST_FIN;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.acc = 1'b1;
                if (col_reg == 2'd2)
                begin
                    col_next   = 2'd3;
                    state_next = ST_ROW;
                end
                else
                begin
                    col_next   = col_reg + 2'd1;
                    state_next = ST_MUL;
                end
            end
            ST_ROW:
            begin
                cmd.row_end = 1'b1;
                col_next    = 2'd0;
                if (row_reg == last_row)
                    state_next = (stat.op == OP_VERTEX) ? ST_DLOAD : ST_FIN;
                else
                begin
                    row_next   = row_reg + 2'd1;
                    state_next = ST_MUL;
                end
            end
            ST_DLOAD:
            begin
                if (stat.w_zero)
                    state_next = ST_FIN;
                else
                begin
                    cmd.div_load = 1'b1;
                    cnt_next     = '0;
                    state_next   = ST_DSTEP;
                end
            end
            ST_DSTEP:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                    state_next = ST_DEND;
            end
            ST_DEND:
            begin
                cmd.div_end = 1'b1;
                if (idx_reg == 2'd2)
                    state_next = ST_FIN;
                else
                begin
                    idx_next   = idx_reg + 2'd1;
                    state_next = ST_DLOAD;
                end
            end
            ST_FIN:
            begin
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            row_reg   <= '0;
            col_reg   <= '0;
            idx_reg   <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            idx_reg   <= idx_next;
            cnt_reg   <= cnt_next;
        end
    end

    // A division never starts on a zero w
    assert property (@(posedge clk) disable iff (!rst_n) cmd.div_load |-> !stat.w_zero)
        else $error("division started with zero w");
    // Results are only produced into a free output register
    assert property (@(posedge clk) disable iff (!rst_n) cmd.finish |-> stat.out_free)
        else $error("result produced while output busy");

endmodule

`default_nettype wire

/* src/hvt_dp.sv */
// Datapath: matrix registers, shared multiplier and accumulator, serial
// restoring divider, bounding box and output register. Depends on hvt_pkg.
`default_nettype none

module hvt_dp #(
    parameter int FRAC_BITS  = hvt_pkg::DEF_FRAC_BITS,
    parameter int COORD_BITS = hvt_pkg::DEF_COORD_BITS
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire hvt_pkg::hvt_cmd_t                cmd,
    output hvt_pkg::hvt_stat_t                    stat,
    input  wire logic [1:0]                       in_op,
    input  wire logic [95:0]                      in_data,
    input  wire logic                             cfg_we,
    input  wire logic [hvt_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic [63:0]                      cfg_data,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic [287:0]                          out_data,
    output logic [1:0]                            out_user
);
    import hvt_pkg::*;

    localparam int C        = COORD_BITS;
    localparam int PW       = 32 + C;
    localparam int ACC_W    = PW + 2;
    localparam int DIV_BITS = C + FRAC_BITS + 1;

    localparam logic signed [ACC_W-1:0] S_HI =
        {{(ACC_W-C+1){1'b0}}, {(C-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] S_LO =
        {{(ACC_W-C+1){1'b1}}, {(C-1){1'b0}}};
    localparam logic signed [PW:0] HALF = (PW+1)'(1) <<< (FRAC_BITS - 1);
    localparam logic [DIV_BITS-1:0] Q_HI = {{(DIV_BITS-C+1){1'b0}}, {(C-1){1'b1}}};
    localparam logic [DIV_BITS-1:0] Q_MAG = Q_HI + 1'b1;
    localparam logic signed [C-1:0] C_HI = {1'b0, {(C-1){1'b1}}};
    localparam logic signed [C-1:0] C_LO = {1'b1, {(C-1){1'b0}}};

    logic [63:0]             pair_reg [NUM_PAIRS];
    logic [1:0]              op_reg;
    logic signed [C-1:0]     v_reg [3];
    logic signed [PW-1:0]    prod_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [C-1:0]     a_reg [4];
    logic signed [C-1:0]     o_reg [3];
    logic [DIV_BITS-1:0]     n_reg;
    logic [C:0]              rem_reg;
    logic [C-1:0]            dvs_reg;
    logic                    neg_reg;
    logic signed [C-1:0]     lo_reg [3];
    logic signed [C-1:0]     hi_reg [3];
    logic                    empty_reg;
    logic                    out_valid_reg;
    logic [287:0]            out_data_reg;
    logic [1:0]              out_user_reg;

    // Matrix entry selection
    logic [3:0]          ent;
    logic [63:0]         pair_sel;
    logic signed [31:0]  m_sel;
    logic signed [C-1:0] v_sel;
    assign ent      = {cmd.row, cmd.col};
    assign pair_sel = pair_reg[ent[3:1]];
    assign m_sel    = ent[0] ? pair_sel[63:32] : pair_sel[31:0];

    always_comb
    begin
        unique case (cmd.col)
            2'd0:    v_sel = v_reg[0];
            2'd1:    v_sel = v_reg[1];
            default: v_sel = v_reg[2];
        endcase
    end

    // Rounded term and row saturation
    logic signed [PW:0]      rnd;
    logic signed [PW:0]      term;
    logic signed [ACC_W-1:0] row_sum;
    logic signed [C-1:0]     row_sat;
    assign rnd     = (PW+1)'(prod_reg) + HALF;
    assign term    = rnd >>> FRAC_BITS;
    assign row_sum = acc_reg + ((op_reg == OP_VERTEX) ? ACC_W'(m_sel) : '0);
    always_comb
    begin
        priority if (row_sum > S_HI)
            row_sat = C_HI;
        else if (row_sum < S_LO)
            row_sat = C_LO;
        else
            row_sat = row_sum[C-1:0];
    end

    // Divider operand setup
    logic signed [C-1:0] a_sel;
    logic [C-1:0]        abs_a, abs_w;
    logic [DIV_BITS-1:0] dividend;
    assign a_sel    = a_reg[cmd.idx];
    assign abs_a    = a_sel[C-1] ? C'(-a_sel) : C'(a_sel);
    assign abs_w    = a_reg[3][C-1] ? C'(-a_reg[3]) : C'(a_reg[3]);
    assign dividend = (DIV_BITS'(abs_a) << FRAC_BITS) + DIV_BITS'(abs_w >> 1);

    // One restoring step
    logic [C:0] rem_sh;
    logic       q_bit;
    assign rem_sh = {rem_reg[C-1:0], n_reg[DIV_BITS-1]};
    assign q_bit  = (rem_sh >= {1'b0, dvs_reg});

    // Quotient sign and saturation
    logic signed [C-1:0] q_sat;
    always_comb
    begin
        if (neg_reg)
        begin
            if (n_reg > Q_MAG)
                q_sat = C_LO;
            else
                q_sat = C'(-n_reg[C-1:0]);
        end
        else
        begin
            if (n_reg > Q_HI)
                q_sat = C_HI;
            else
                q_sat = n_reg[C-1:0];
        end
    end

    // Box merge values
    logic                merge;
    logic signed [C-1:0] lo_next [3];
    logic signed [C-1:0] hi_next [3];
    logic                empty_next;
    assign merge = (op_reg == OP_VERTEX) && (a_reg[3] != '0);
    always_comb
    begin
        empty_next = empty_reg;
        for (int i = 0; i < 3; i++)
        begin
            lo_next[i] = lo_reg[i];
            hi_next[i] = hi_reg[i];
            if (op_reg == OP_CLEAR)
            begin
                lo_next[i] = '0;
                hi_next[i] = '0;
            end
            else if (merge)
            begin
                if (empty_reg || o_reg[i] < lo_reg[i])
                    lo_next[i] = o_reg[i];
                if (empty_reg || o_reg[i] > hi_reg[i])
                    hi_next[i] = o_reg[i];
            end
        end
        if (op_reg == OP_CLEAR)
            empty_next = 1'b1;
        else if (merge)
            empty_next = 1'b0;
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_PAIRS; i++)
                pair_reg[i] <= pair_reset(PAIR_IDX_BITS'(i));
        end
        else if (cfg_we && cfg_index < CFG_IDX_BITS'(NUM_PAIRS))
            pair_reg[cfg_index[PAIR_IDX_BITS-1:0]] <= cfg_data;
    end

    // Item registers, multiplier, accumulator and divider
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            op_reg   <= in_op;
            v_reg[0] <= in_data[C-1:0];
            v_reg[1] <= in_data[32+C-1:32];
            v_reg[2] <= in_data[64+C-1:64];
            acc_reg  <= '0;
            for (int i = 0; i < 3; i++)
                o_reg[i] <= '0;
        end
        if (cmd.mul)
            prod_reg <= PW'(m_sel) * PW'(v_sel);
        if (cmd.acc)
            acc_reg <= acc_reg + ACC_W'(term);
        if (cmd.row_end)
        begin
            a_reg[cmd.row] <= row_sat;
            acc_reg        <= '0;
            if (op_reg == OP_NORMAL)
                o_reg[cmd.row] <= row_sat;
        end
        if (cmd.div_load)
        begin
            n_reg   <= dividend;
            rem_reg <= '0;
            dvs_reg <= abs_w;
            neg_reg <= a_sel[C-1] ^ a_reg[3][C-1];
        end
        if (cmd.div_step)
        begin
            rem_reg <= q_bit ? (rem_sh - {1'b0, dvs_reg}) : rem_sh;
            n_reg   <= {n_reg[DIV_BITS-2:0], q_bit};
        end
        if (cmd.div_end)
            o_reg[cmd.idx] <= q_sat;
    end

    // Bounding box
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                lo_reg[i] <= '0;
                hi_reg[i] <= '0;
            end
            empty_reg <= 1'b1;
        end
        else if (cmd.finish)
        begin
            for (int i = 0; i < 3; i++)
            begin
                lo_reg[i] <= lo_next[i];
                hi_reg[i] <= hi_next[i];
            end
            empty_reg <= empty_next;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.finish)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_data_reg <= {32'(hi_next[2]), 32'(hi_next[1]), 32'(hi_next[0]),
                             32'(lo_next[2]), 32'(lo_next[1]), 32'(lo_next[0]),
                             32'(o_reg[2]), 32'(o_reg[1]), 32'(o_reg[0])};
            out_user_reg <= {(op_reg == OP_VERTEX) && (a_reg[3] == '0), empty_next};
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_data      = out_data_reg;
    assign out_user      = out_user_reg;
    assign stat.op       = op_reg;
    assign stat.w_zero   = (a_reg[3] == '0);
    assign stat.out_free = !out_valid_reg || out_ready;

    // A clear item leaves the box empty
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish && op_reg == OP_CLEAR |=> empty_reg)
        else $error("box not empty after clear");
    // Every produced result raises the output valid flag
    assert property (@(posedge clk) disable iff (!rst_n) cmd.finish |=> out_valid_reg)
        else $error("result lost");

endmodule

`default_nettype wire

/* src/homogeneous_vertex_transform_bbox_unit.sv */
// Top level of the homogeneous vertex transform and bounding-box unit.
// Instantiates hvt_ctrl and hvt_dp; depends on hvt_pkg.
//
// One item at a time goes through a single 32xCOORD_BITS multiplier, with a
// multiply and an accumulate step for each of three matrix columns plus a row
// step per matrix row, and a restoring divider that produces one quotient bit
// per cycle over COORD_BITS+FRAC_BITS+1 steps. A vertex runs four matrix rows
// and then three divisions (skipped if w is zero), a normal three rows; a
// clear or no-op item goes straight to the finish step. The finished result
// sits in an output register, so the next item is taken while it waits;
// configuration writes are accepted every cycle.
`default_nettype none

module homogeneous_vertex_transform_bbox_unit #(
    parameter int FRAC_BITS  = hvt_pkg::DEF_FRAC_BITS,
    parameter int COORD_BITS = hvt_pkg::DEF_COORD_BITS
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [95:0]                      s_tdata,   // in_x, in_y, in_z
    input  wire logic [1:0]                       s_tuser,   // op
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // out_x, out_y, out_z, min_x, min_y, min_z, max_x, max_y, max_z
    output logic [287:0]                          m_tdata,
    output logic [1:0]                            m_tuser,   // box_is_empty, divide_fault
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [hvt_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic [63:0]                      cfg_data
);
    import hvt_pkg::*;

    hvt_cmd_t  cmd;
    hvt_stat_t stat;

    assign cfg_ready = 1'b1;

    hvt_ctrl #(
        .DIV_BITS(COORD_BITS + FRAC_BITS + 1)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(s_tvalid),
        .in_op   (s_tuser),
        .in_ready(s_tready),
        .stat    (stat),
        .cmd     (cmd)
    );

    hvt_dp #(
        .FRAC_BITS (FRAC_BITS),
        .COORD_BITS(COORD_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .in_op    (s_tuser),
        .in_data  (s_tdata),
        .cfg_we   (cfg_valid),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .out_data (m_tdata),
        .out_user (m_tuser)
    );

endmodule

`default_nettype wire
